// File: sv/dttn_pkg.sv
// Shared constants, tables and control types of the decimal text parser.
`default_nettype none

package dttn_pkg;

    // Result format.
    localparam int VALUE_BITS      = 48;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;

    // The magnitude is one bit narrower than the signed value.
    localparam int MAG_W = VALUE_BITS - 1;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // The scaled numerator is the mantissa shifted left by the fraction bits.
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W);

    // The divisor is a power of ten up to ten to the MAX_FRAC_DIGITS.
    localparam longint unsigned POW10_MAX = 64'd10 ** MAX_FRAC_DIGITS;
    localparam int DIV_W = $clog2(POW10_MAX + 64'd1);

    // Fraction digit count and consumed character count.
    localparam int FD_W    = 4;
    localparam int COUNT_W = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef logic [DIV_W-1:0] pow10_tab_t [0:(1 << FD_W) - 1];

    // Powers of ten indexed by the fraction digit count; entries past the
    // digit limit repeat the largest power.
    function automatic pow10_tab_t make_pow10_tab();
        pow10_tab_t     tab;
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < (1 << FD_W); i++) begin
            tab[i] = DIV_W'(p);
            if (i < MAX_FRAC_DIGITS) begin
                p = p * 64'd10;
            end
        end
        return tab;
    endfunction

    localparam pow10_tab_t POW10_TAB = make_pow10_tab();

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sign;
        logic add_digit;
        logic count_frac;
        logic mark_digit;
        logic count_char;
        logic capture_stop;
        logic div_start;
        logic div_step;
        logic load_result;
    } dttn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sign;
        logic is_digit;
        logic is_point;
        logic frac_mode;
        logic frac_full;
        logic div_last;
        logic out_free;
    } dttn_stat_t;

endpackage

`default_nettype wire

// File: sv/dttn_datapath.sv
// Datapath of the decimal text parser: mantissa, counters, divider, result register.
`default_nettype none

module dttn_datapath
    import dttn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_data,
    input  wire logic [7:0]            s_character,
    input  wire dttn_cmd_t             cmd,
    output dttn_stat_t                 stat,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic signed [VALUE_BITS-1:0] m_value,
    output logic                       m_digits_seen,
    output logic                       m_overflowed,
    output logic [COUNT_W-1:0]         m_consumed_count,
    output logic [7:0]                 m_stop_character
);

    logic                  frac_mode_reg;
    logic                  neg_reg,   neg_next;
    logic                  any_reg,   any_next;
    logic                  sat_reg,   sat_next;
    logic [MAG_W-1:0]      mant_reg,  mant_next;
    logic [FD_W-1:0]       fd_reg,    fd_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  scale_reg;
    logic [7:0]            stop_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic                  out_valid_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic                  out_digits_reg;
    logic                  out_ovf_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [7:0]            out_stop_reg;

    logic [3:0]            digit;
    logic [MAG_W+3:0]      mant_x10;
    logic [DIV_W:0]        rem_shift;
    logic                  rem_ge;
    logic                  quot_over;
    logic [MAG_W-1:0]      mag;
    logic                  ovf;
    logic [VALUE_BITS-1:0] mag_ext;

    // Character classification.
    assign digit          = 4'(s_character - CHAR_ZERO);
    assign stat.is_digit  = (s_character >= CHAR_ZERO) && (s_character <= CHAR_NINE);
    assign stat.is_sign   = (s_character == CHAR_PLUS) || (s_character == CHAR_MINUS);
    assign stat.is_point  = (s_character == CHAR_POINT);
    assign stat.frac_mode = frac_mode_reg;
    assign stat.frac_full = (fd_reg >= FD_W'(MAX_FRAC_DIGITS));
    assign stat.div_last  = (dcnt_reg == DCNT_W'(NUM_W - 1));
    assign stat.out_free  = !out_valid_reg || m_ready;

    // Mantissa times ten plus the digit, by shift and add.
    assign mant_x10 = ({4'b0, mant_reg} << 3) + ({4'b0, mant_reg} << 1)
                    + (MAG_W + 4)'(digit);

    // Parse state update.
    always_comb begin
        neg_next   = neg_reg;
        any_next   = any_reg;
        sat_next   = sat_reg;
        mant_next  = mant_reg;
        fd_next    = fd_reg;
        count_next = count_reg;
        if (cmd.load_result) begin
            neg_next   = 1'b0;
            any_next   = 1'b0;
            sat_next   = 1'b0;
            mant_next  = '0;
            fd_next    = '0;
            count_next = '0;
        end else begin
            if (cmd.load_sign) begin
                neg_next = (s_character == CHAR_MINUS);
            end
            if (cmd.add_digit) begin
                if (mant_x10 > (MAG_W + 4)'(MAG_MAX)) begin
                    mant_next = MAG_MAX;
                    sat_next  = 1'b1;
                end else begin
                    mant_next = mant_x10[MAG_W-1:0];
                end
            end
            if (cmd.count_frac) begin
                fd_next = fd_reg + FD_W'(1);
            end
            if (cmd.mark_digit) begin
                any_next = 1'b1;
            end
            if (cmd.count_char && (count_reg != COUNT_MAX)) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // One restoring division step: one quotient bit per cycle.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // Result magnitude, saturated, and its sign.
    assign quot_over = (num_reg > NUM_W'(MAG_MAX));
    always_comb begin
        if (scale_reg) begin
            mag = quot_over ? MAG_MAX : num_reg[MAG_W-1:0];
            ovf = sat_reg || quot_over;
        end else begin
            mag = mant_reg;
            ovf = sat_reg;
        end
    end
    assign mag_ext = {1'b0, mag};

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_mode_reg <= 1'b0;
            neg_reg       <= 1'b0;
            any_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            mant_reg      <= '0;
            fd_reg        <= '0;
            count_reg     <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                frac_mode_reg <= cfg_data;
            end
            neg_reg   <= neg_next;
            any_reg   <= any_next;
            sat_reg   <= sat_next;
            mant_reg  <= mant_next;
            fd_reg    <= fd_next;
            count_reg <= count_next;
            if (cmd.div_start) begin
                dcnt_reg <= '0;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (cmd.load_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: stop capture, divider and result.
    always_ff @(posedge aclk) begin
        if (cmd.capture_stop) begin
            stop_reg  <= s_character;
            scale_reg <= frac_mode_reg;
        end
        if (cmd.div_start) begin
            num_reg <= NUM_W'(mant_reg) << FRAC_BITS;
            rem_reg <= '0;
            div_reg <= POW10_TAB[fd_reg];
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[NUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? DIV_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DIV_W-1:0];
        end
        if (cmd.load_result) begin
            out_value_reg  <= neg_reg ? -$signed(mag_ext) : $signed(mag_ext);
            out_digits_reg <= any_reg;
            out_ovf_reg    <= ovf;
            out_count_reg  <= count_reg;
            out_stop_reg   <= stop_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_value          = out_value_reg;
    assign m_digits_seen    = out_digits_reg;
    assign m_overflowed     = out_ovf_reg;
    assign m_consumed_count = out_count_reg;
    assign m_stop_character = out_stop_reg;

endmodule

`default_nettype wire

// File: sv/dttn_ctrl.sv
// Controller of the decimal text parser: parse phases, division and result hand-off.
`default_nettype none

module dttn_ctrl
    import dttn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dttn_stat_t stat,
    output dttn_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_SIGN,
        S_INT,
        S_FRAC,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // Characters are taken only in the parse phases.
    assign s_ready = (state_reg == S_SIGN) || (state_reg == S_INT) || (state_reg == S_FRAC);

    // Next state and commands.
    always_comb begin
        logic stop;
        stop       = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_SIGN, S_INT: begin
                if (s_valid) begin
                    if ((state_reg == S_SIGN) && stat.is_sign) begin
                        cmd.load_sign  = 1'b1;
                        cmd.count_char = 1'b1;
                        state_next     = S_INT;
                    end else if (stat.is_digit) begin
                        cmd.add_digit  = 1'b1;
                        cmd.mark_digit = 1'b1;
                        cmd.count_char = 1'b1;
                        state_next     = S_INT;
                    end else if (stat.is_point && stat.frac_mode) begin
                        cmd.count_char = 1'b1;
                        state_next     = S_FRAC;
                    end else begin
                        stop = 1'b1;
                    end
                end
            end
            S_FRAC: begin
                if (s_valid) begin
                    if (stat.is_digit) begin
                        // Digits past the limit are counted but dropped.
                        cmd.add_digit  = !stat.frac_full;
                        cmd.count_frac = !stat.frac_full;
                        cmd.mark_digit = 1'b1;
                        cmd.count_char = 1'b1;
                    end else begin
                        stop = 1'b1;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_SIGN;
                end
            end
            default: begin
                state_next = S_SIGN;
            end
        endcase

        // A stopping character ends the number; fraction mode scales it first.
        if (stop) begin
            cmd.capture_stop = 1'b1;
            if (stat.frac_mode) begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end else begin
                state_next = S_FIN;
            end
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SIGN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/decimal_text_to_number.sv
// Top level of the decimal text parser: controller, datapath and ports.
// Characters are taken one per cycle while a number is being parsed.
// Integer mode: the result is loaded in S_FIN once the output is free.
// Fraction mode: a bit-serial divider in S_DIV first scales the NUM_W (63)-bit numerator.
// The input is not ready between the stopping character and the result load.
// Reset (aresetn, synchronous, active low) clears fraction_mode and the parse.
`default_nettype none

module decimal_text_to_number
    import dttn_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_character,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VALUE_BITS-1:0] m_value,
    output logic                         m_digits_seen,
    output logic                         m_overflowed,
    output logic [COUNT_W-1:0]           m_consumed_count,
    output logic [7:0]                   m_stop_character
);

    dttn_cmd_t  cmd;
    dttn_stat_t stat;

    // The mode register is always writable.
    assign cfg_ready = 1'b1;

    dttn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dttn_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_character      (s_character),
        .cmd              (cmd),
        .stat             (stat),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_value          (m_value),
        .m_digits_seen    (m_digits_seen),
        .m_overflowed     (m_overflowed),
        .m_consumed_count (m_consumed_count),
        .m_stop_character (m_stop_character)
    );

endmodule

`default_nettype wire

// File: sv/dttn_checker.sv
// Port-level assertions of the decimal text parser and their bind.
`default_nettype none

module dttn_checker
    import dttn_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    cfg_valid,
    input wire logic                    cfg_ready,
    input wire logic                    cfg_data,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic [7:0]              s_character,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [VALUE_BITS-1:0] m_value,
    input wire logic                    m_digits_seen,
    input wire logic                    m_overflowed,
    input wire logic [COUNT_W-1:0]      m_consumed_count,
    input wire logic [7:0]              m_stop_character
);

    // A waiting item stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // A waiting item keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_value) && $stable(m_stop_character))
        else $error("result item changed while stalled");

    // With no digits the value is zero and nothing saturated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_digits_seen |-> (m_value == '0) && !m_overflowed)
        else $error("item without digits carries a value");

    // A digit always counts as a consumed character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_digits_seen |-> (m_consumed_count != '0))
        else $error("digits seen but none consumed");

endmodule

bind decimal_text_to_number dttn_checker u_dttn_checker (.*);

`default_nettype wire

// File: test/decimal_text_to_number_tb.sv
// Self-checking testbench for the decimal text parser, with its own parse predictor.
module decimal_text_to_number_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dttn_pkg::*;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          MAX_PRINTED  = 40;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [7:0]  CHAR_TOP     = 8'hFF;

    typedef enum logic [1:0] {
        AWAIT_SIGN  = 2'd0,
        INT_DIGITS  = 2'd1,
        FRAC_DIGITS = 2'd2
    } parse_phase_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         digits_seen;
        logic                         overflowed;
        logic [COUNT_W-1:0]           consumed;
        logic [7:0]                   stop_char;
    } parsed_number_t;

    // Clock, reset and block ports.
    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         cfg_data  = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_character = 8'h00;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    logic signed [VALUE_BITS-1:0] m_value;
    logic                         m_digits_seen;
    logic                         m_overflowed;
    logic [COUNT_W-1:0]           m_consumed_count;
    logic [7:0]                   m_stop_character;

    // Predicted parser state and the mode register.
    bit                 frac_mode_m    = 1'b0;
    parse_phase_t       phase_m        = AWAIT_SIGN;
    bit                 negative_m     = 1'b0;
    bit                 any_digit_m    = 1'b0;
    bit                 saturated_m    = 1'b0;
    logic [MAG_W-1:0]   mantissa_m     = '0;
    logic [FD_W-1:0]    frac_digits_m  = '0;
    logic [COUNT_W-1:0] char_count_m   = '0;

    // Numbers predicted but not yet delivered, oldest first.
    parsed_number_t expected_numbers[$];
    parsed_number_t oldest_number;

    // Stimulus knobs and bookkeeping.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    decimal_text_to_number uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_character      (s_character),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_digits_seen    (m_digits_seen),
        .m_overflowed     (m_overflowed),
        .m_consumed_count (m_consumed_count),
        .m_stop_character (m_stop_character)
    );

    always #6 aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
        end
    endtask

    // Saturating count of consumed characters.
    function automatic void bump_count();
        if (char_count_m != COUNT_MAX) begin
            char_count_m++;
        end
    endfunction

    // Append one decimal digit to the magnitude, clamping at the largest value.
    function automatic void accumulate_digit(input logic [7:0] ch);
        longint unsigned d;
        longint unsigned m;
        d = ch - CHAR_ZERO;
        m = mantissa_m;
        if (m > (64'(MAG_MAX) - d) / 10) begin
            mantissa_m  = MAG_MAX;
            saturated_m = 1'b1;
        end else begin
            mantissa_m = MAG_W'(m * 10 + d);
        end
    endfunction

    // Advance the parse by one character; returns 1 when it ends a number.
    function automatic bit parse_character(input logic [7:0] ch,
                                           output parsed_number_t num);
        bit              digit;
        bit              ovf;
        longint unsigned mag;
        longint unsigned pow;
        longint unsigned quo;
        longint unsigned rem;
        digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

        // A sign is only taken as the very first character.
        if (phase_m != INT_DIGITS && phase_m != FRAC_DIGITS) begin
            if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
                negative_m = (ch == CHAR_MINUS);
                bump_count();
                phase_m = INT_DIGITS;
                return 1'b0;
            end
            phase_m = INT_DIGITS;
        end

        if (phase_m == INT_DIGITS) begin
            if (digit) begin
                accumulate_digit(ch);
                any_digit_m = 1'b1;
                bump_count();
                return 1'b0;
            end
            if (ch == CHAR_POINT && frac_mode_m) begin
                bump_count();
                phase_m = FRAC_DIGITS;
                return 1'b0;
            end
        end else if (digit) begin
            // Fraction digits past the limit are consumed but dropped.
            if (frac_digits_m < MAX_FRAC_DIGITS) begin
                accumulate_digit(ch);
                frac_digits_m++;
            end
            any_digit_m = 1'b1;
            bump_count();
            return 1'b0;
        end

        // The character ends the number; scale the magnitude in fraction mode.
        ovf = saturated_m;
        mag = mantissa_m;
        if (frac_mode_m) begin
            pow = 1;
            for (int i = 0; i < frac_digits_m; i++) begin
                pow = pow * 10;
            end
            quo = mag / pow;
            rem = mag % pow;
            if (quo > (64'(MAG_MAX) >> FRAC_BITS)) begin
                ovf = 1'b1;
                mag = MAG_MAX;
            end else begin
                mag = (quo << FRAC_BITS) + (rem << FRAC_BITS) / pow;
                if (mag > MAG_MAX) begin
                    ovf = 1'b1;
                    mag = MAG_MAX;
                end
            end
        end
        num.value       = VALUE_BITS'(negative_m ? -mag : mag);
        num.digits_seen = any_digit_m;
        num.overflowed  = ovf;
        num.consumed    = char_count_m;
        num.stop_char   = ch;

        phase_m       = AWAIT_SIGN;
        negative_m    = 1'b0;
        any_digit_m   = 1'b0;
        saturated_m   = 1'b0;
        mantissa_m    = '0;
        frac_digits_m = '0;
        char_count_m  = '0;
        return 1'b1;
    endfunction

    // Offer one character after a random gap and predict once it is taken.
    task automatic send_char(input logic [7:0] ch);
        parsed_number_t num;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        if (parse_character(ch, num)) begin
            expected_numbers.push_back(num);
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    // Drop valid, then wait until every predicted number has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_numbers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_fraction_mode(input bit mode);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        frac_mode_m = mode;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One number of random shape, or now and then a single noise byte.
    task automatic send_random_number();
        int         pick;
        int         n_int;
        int         n_frac;
        logic [7:0] stop;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_char(8'($urandom_range(255)));
            return;
        end
        case ($urandom_range(2))
            1: send_char(CHAR_PLUS);
            2: send_char(CHAR_MINUS);
            default: ;
        endcase
        pick  = $urandom_range(99);
        n_int = (pick < 70) ? $urandom_range(4) :
                (pick < 90) ? $urandom_range(10, 5) : $urandom_range(18, 11);
        repeat (n_int) send_char(CHAR_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(99) < (frac_mode_m ? 65 : 15)) begin
            send_char(CHAR_POINT);
            n_frac = ($urandom_range(99) < 75) ? $urandom_range(5) : $urandom_range(13, 6);
            repeat (n_frac) send_char(CHAR_ZERO + 8'($urandom_range(9)));
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            stop = CHAR_NUL;
        end else if (pick < 45) begin
            stop = CHAR_POINT;
        end else if (pick < 55) begin
            stop = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
        end else begin
            stop = 8'($urandom_range(255));
        end
        send_char(stop);
    endtask

    task automatic send_random_items(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            send_random_number();
        end
    endtask

    // Integer mode straight after reset: lone sign, extreme stop byte, point.
    task automatic test_integer_stops();
        send_text("+");
        send_char(CHAR_TOP);
        send_text("7.");
    endtask

    // The mode is changed while a number is half parsed, both ways.
    task automatic test_mode_switch_mid_number();
        send_text("-");
        wait_drained();
        write_fraction_mode(1'b1);
        send_text(".5");
        send_char(CHAR_NUL);
        send_text("2.5");
        wait_drained();
        write_fraction_mode(1'b0);
        send_char(CHAR_NUL);
    endtask

    // Fraction mode limits: second point, lone point, saturation, result clamp.
    task automatic test_fraction_limits();
        wait_drained();
        write_fraction_mode(1'b1);
        send_text("1.5.");
        send_text(". ");
        send_text("-999999.9999999999");
        send_char(CHAR_NUL);
        send_text("2147483648");
        send_char(CHAR_NUL);
    endtask

    task automatic test_random_no_idle();
        wait_drained();
        write_fraction_mode(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_items(450);
    endtask

    task automatic test_random_sender_idle();
        wait_drained();
        write_fraction_mode(1'b0);
        send_idle_pct  = 77;
        recv_stall_pct = 0;
        send_random_items(450);
    endtask

    task automatic test_random_receiver_stall();
        wait_drained();
        write_fraction_mode(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        send_random_items(450);
    endtask

    task automatic test_random_both_idle();
        wait_drained();
        write_fraction_mode(1'b0);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        send_random_items(450);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        wait_drained();
        write_fraction_mode(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 600;
        repeat (12) send_random_number();
    endtask

    // Result side ready, with random stalls and long hold-offs on request.
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each delivered item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_numbers.size() == 0) begin
                report_mismatch("result item arrived with none predicted");
            end else begin
                oldest_number = expected_numbers.pop_front();
                check_field("value", m_value, oldest_number.value);
                check_field("digits_seen", m_digits_seen, oldest_number.digits_seen);
                check_field("overflowed", m_overflowed, oldest_number.overflowed);
                check_field("consumed_count", m_consumed_count, oldest_number.consumed);
                check_field("stop_character", m_stop_character, oldest_number.stop_char);
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_integer_stops();
        test_mode_switch_mid_number();
        test_fraction_limits();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_backpressure();

        wait_drained();
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
sv/dttn_pkg.sv
sv/dttn_datapath.sv
sv/dttn_ctrl.sv
sv/decimal_text_to_number.sv
sv/dttn_checker.sv
test/decimal_text_to_number_tb.sv
